[rtl/ordered_dither_colorcube_core_macros.svh]
// Assertion macros of the ordered dither colorcube core RTL.
`ifndef ORDERED_DITHER_COLORCUBE_CORE_MACROS_SVH
`define ORDERED_DITHER_COLORCUBE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during reset.
`define ODCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled during reset.
`define ODCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/odcc_pkg.sv]
// Shared types and constants of the ordered dither colorcube block.
package odcc_pkg;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  localparam logic [3:0] REG_BAND_COUNT  = 4'd0;
  localparam logic [3:0] REG_CUBE_OFFSET = 4'd1;
  localparam logic [3:0] REG_MASK_WIDTH  = 4'd2;
  localparam logic [3:0] REG_MASK_HEIGHT = 4'd3;
  localparam logic [3:0] REG_BAND0_COEFF = 4'd4;
  localparam logic [3:0] REG_BAND1_COEFF = 4'd5;
  localparam logic [3:0] REG_BAND2_COEFF = 4'd6;
  localparam logic [3:0] REG_BAND3_COEFF = 4'd7;

  localparam logic [15:0] SAMPLE_BIAS = 16'h8000;

  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } lane_ctrl_t;

endpackage

[rtl/odcc_lane.sv]
// One band lane: scale product, threshold memory, dither compare and weighting.
module odcc_lane #(
  parameter int MASK_W = 16,
  parameter int MASK_H = 16
) (
  input  logic                           clk,
  input  odcc_pkg::lane_ctrl_t           ctrl,
  input  logic [15:0]                    sample,
  input  logic [15:0]                    dim,
  input  logic signed [16:0]             mult,
  input  logic                           active,
  input  logic [(MASK_W > 1 ? $clog2(MASK_W) : 1)-1:0] rd_col,
  input  logic [(MASK_H > 1 ? $clog2(MASK_H) : 1)-1:0] rd_row,
  input  logic                           wr_en,
  input  logic [(MASK_W > 1 ? $clog2(MASK_W) : 1)-1:0] wr_col,
  input  logic [(MASK_H > 1 ? $clog2(MASK_H) : 1)-1:0] wr_row,
  input  logic [15:0]                    wr_value,
  output logic signed [33:0]             term
);
  import odcc_pkg::*;

  localparam int DEPTH = MASK_W * MASK_H;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic [15:0]        mem [DEPTH];
  logic [31:0]        prod2_r, prod3_r, prod4_r;
  logic [15:0]        thr4_r;
  logic signed [33:0] term5_r;
  logic [15:0]        biased;
  logic [31:0]        prod_nxt;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [15:0]        qe;
  logic signed [33:0] term_nxt;

  assign biased   = sample ^ SAMPLE_BIAS;
  assign prod_nxt = {16'd0, biased} * {16'd0, dim};
  assign rd_addr  = AW'(rd_row * MASK_W + rd_col);
  assign wr_addr  = AW'(wr_row * MASK_W + wr_col);
  assign qe       = prod4_r[31:16] + {15'd0, (prod4_r[15:0] > thr4_r)};
  assign term_nxt = $signed({1'b0, qe}) * mult;

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      prod2_r <= prod_nxt;
    end
    if (ctrl.en3) begin
      prod3_r <= prod2_r;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_value;
    end
    if (ctrl.en4) begin
      prod4_r <= prod3_r;
      thr4_r  <= mem[rd_addr];
    end
    if (ctrl.en5) begin
      term5_r <= active ? term_nxt : '0;
    end
  end

  assign term = term5_r;

endmodule

[rtl/ordered_dither_colorcube_core.sv]
// Top level of the ordered dither colorcube block: stream ports and pipeline.
//
//  Channel  Direction  Handshake             Payload
//  in_      slave      in_tvalid/in_tready   tdata: pixel and load fields, tuser: opcode
//  out_     master     out_tvalid/out_tready tdata: color index, tuser: nonzero flag
//  cfg_     slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One word is accepted per cycle while in_tready is high; a pixel's result passes through seven pipeline
// registers (input, two remainder stages with the scale product beside the first, the threshold
// memory read, the weighting multiplier and a two-level sum).
// Load words write their lane's threshold memory at stage four and then leave the pipeline.
// Every stage has its own ready, so empty stages fill while the output is stalled.
// Reset clears the valid bits and configuration registers only; threshold memories need no clearing.
`include "ordered_dither_colorcube_core_macros.svh"

module ordered_dither_colorcube_core #(
  parameter int MAX_BANDS  = 4,
  parameter int MAX_MASK_W = 16,
  parameter int MAX_MASK_H = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // sample0, sample1, sample2, sample3, pos_x, pos_y, load_band, load_col,
  // load_row, load_value, zero fill
  input  logic [127:0] in_tdata,
  // opcode
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // color_index
  output logic [15:0]  out_tdata,
  // index_nonzero
  output logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [32:0]  cfg_data
);
  import odcc_pkg::*;

  localparam int CW    = MAX_MASK_W > 1 ? $clog2(MAX_MASK_W) : 1;
  localparam int RW    = MAX_MASK_H > 1 ? $clog2(MAX_MASK_H) : 1;
  localparam int MAXWH = MAX_MASK_W > MAX_MASK_H ? MAX_MASK_W : MAX_MASK_H;
  localparam int DW    = $clog2(MAXWH + 1);

  logic [2:0]         band_count_r;
  logic signed [16:0] cube_offset_r;
  logic [4:0]         mask_width_r, mask_height_r;
  logic [32:0]        coeff_r [4];

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic en1, en2, en3, en4, en5, en6, en7;

  logic        op1_r, op2_r, op3_r;
  logic [15:0] smp1_r [4];
  logic [15:0] px1_r, py1_r;
  logic [7:0]  px2_r, py2_r;
  logic [1:0]  lb1_r, lb2_r, lb3_r;
  logic [3:0]  lc1_r, lc2_r, lc3_r;
  logic [3:0]  lr1_r, lr2_r, lr3_r;
  logic [15:0] lv1_r, lv2_r, lv3_r;
  logic [DW-1:0] rx2_r, ry2_r;
  logic [CW-1:0] col3_r;
  logic [RW-1:0] row3_r;
  logic [DW-1:0] rx3_nxt, ry3_nxt;

  logic [DW-1:0] w_div, h_div;
  logic [3:0]    active;
  logic          load_ok;
  lane_ctrl_t    lane_ctrl;

  logic signed [33:0] term_w [4];
  logic signed [34:0] p0_r, p1_r;
  logic signed [35:0] sum_nxt;
  logic [15:0]        index_r;
  logic               nonzero_r;

  function automatic logic [DW-1:0] rem_step8(logic [DW-1:0] r_in, logic [7:0] bits,
                                              logic [DW-1:0] d);
    logic [DW:0]   t;
    logic [DW-1:0] r;
    r = r_in;
    for (int i = 7; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      r = t[DW-1:0];
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_count_r  <= 3'd1;
      cube_offset_r <= '0;
      mask_width_r  <= 5'd4;
      mask_height_r <= 5'd4;
      for (int k = 0; k < 4; k++) begin
        coeff_r[k] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BAND_COUNT:  band_count_r  <= cfg_data[2:0];
        REG_CUBE_OFFSET: cube_offset_r <= $signed(cfg_data[16:0]);
        REG_MASK_WIDTH:  mask_width_r  <= cfg_data[4:0];
        REG_MASK_HEIGHT: mask_height_r <= cfg_data[4:0];
        REG_BAND0_COEFF: coeff_r[0]    <= cfg_data;
        REG_BAND1_COEFF: coeff_r[1]    <= cfg_data;
        REG_BAND2_COEFF: coeff_r[2]    <= cfg_data;
        REG_BAND3_COEFF: coeff_r[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (mask_width_r == 5'd0) begin
      w_div = DW'(1);
    end else if (32'(mask_width_r) > MAX_MASK_W) begin
      w_div = DW'(MAX_MASK_W);
    end else begin
      w_div = DW'(mask_width_r);
    end
    if (mask_height_r == 5'd0) begin
      h_div = DW'(1);
    end else if (32'(mask_height_r) > MAX_MASK_H) begin
      h_div = DW'(MAX_MASK_H);
    end else begin
      h_div = DW'(mask_height_r);
    end
    for (int k = 0; k < 4; k++) begin
      active[k] = (32'(band_count_r) > k) && (k < MAX_BANDS);
    end
  end

  assign en7 = !out_valid_r || out_tready;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r && (op3_r == OP_PIXEL);
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) out_valid_r <= v6_r;
    end
  end

  assign rx3_nxt = rem_step8(rx2_r, px2_r, w_div);
  assign ry3_nxt = rem_step8(ry2_r, py2_r, h_div);

  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r <= in_tuser[0];
      for (int k = 0; k < 4; k++) begin
        smp1_r[k] <= in_tdata[16*k +: 16];
      end
      px1_r <= in_tdata[79:64];
      py1_r <= in_tdata[95:80];
      lb1_r <= in_tdata[97:96];
      lc1_r <= in_tdata[101:98];
      lr1_r <= in_tdata[105:102];
      lv1_r <= in_tdata[121:106];
    end
    if (en2) begin
      op2_r <= op1_r;
      rx2_r <= rem_step8('0, px1_r[15:8], w_div);
      ry2_r <= rem_step8('0, py1_r[15:8], h_div);
      px2_r <= px1_r[7:0];
      py2_r <= py1_r[7:0];
      lb2_r <= lb1_r;
      lc2_r <= lc1_r;
      lr2_r <= lr1_r;
      lv2_r <= lv1_r;
    end
    if (en3) begin
      op3_r  <= op2_r;
      col3_r <= rx3_nxt[CW-1:0];
      row3_r <= ry3_nxt[RW-1:0];
      lb3_r  <= lb2_r;
      lc3_r  <= lc2_r;
      lr3_r  <= lr2_r;
      lv3_r  <= lv2_r;
    end
  end

  assign load_ok = en4 && v3_r && (op3_r == OP_LOAD) && (32'(lb3_r) < MAX_BANDS)
                   && (32'(lc3_r) < MAX_MASK_W) && (32'(lr3_r) < MAX_MASK_H);

  assign lane_ctrl.en2 = en2;
  assign lane_ctrl.en3 = en3;
  assign lane_ctrl.en4 = en4;
  assign lane_ctrl.en5 = en5;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    if (k < MAX_BANDS) begin : g_on
      odcc_lane #(
        .MASK_W(MAX_MASK_W),
        .MASK_H(MAX_MASK_H)
      ) u_lane (
        .clk      (clk),
        .ctrl     (lane_ctrl),
        .sample   (smp1_r[k]),
        .dim      (coeff_r[k][15:0]),
        .mult     ($signed(coeff_r[k][32:16])),
        .active   (active[k]),
        .rd_col   (col3_r),
        .rd_row   (row3_r),
        .wr_en    (load_ok && (lb3_r == 2'(k))),
        .wr_col   (CW'(lc3_r)),
        .wr_row   (RW'(lr3_r)),
        .wr_value (lv3_r),
        .term     (term_w[k])
      );
    end else begin : g_off
      assign term_w[k] = '0;
    end
  end

  assign sum_nxt = 36'(cube_offset_r) + 36'(p0_r) + 36'(p1_r);

  always_ff @(posedge clk) begin
    if (en6) begin
      p0_r <= 35'(term_w[0]) + 35'(term_w[1]);
      p1_r <= 35'(term_w[2]) + 35'(term_w[3]);
    end
    if (en7) begin
      index_r   <= sum_nxt[15:0];
      nonzero_r <= (sum_nxt != '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = index_r;
  assign out_tuser  = nonzero_r;

  `ODCC_ASSERT_NOW(a_zero_flag, out_valid_r && !nonzero_r, index_r == 16'd0, "zero sum with nonzero index")
  `ODCC_ASSERT_NEXT(a_load_drops, v3_r && (op3_r == OP_LOAD) && en4, !v4_r, "load word passed stage four")
  `ODCC_ASSERT_NEXT(a_out_fill, v6_r && en7, out_valid_r, "result lost before the output register")
  `ODCC_ASSERT_NOW(a_fill_empty, !v1_r, in_tready, "input stalled with empty first stage")

endmodule

[sim/ordered_dither_colorcube_core_tb.sv]
// Self-checking testbench of the ordered dither colorcube core with random stream stalls.
`timescale 1ns / 1ps

module ordered_dither_colorcube_core_tb;
  import odcc_pkg::*;

  localparam int MAX_BANDS = 4;
  localparam int MAX_MASK_W = 16;
  localparam int MAX_MASK_H = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS = 250;

  typedef struct packed {
    logic [15:0] index;
    logic        nonzero;
  } color_t;

  class colorcube_scoreboard;
    logic [15:0]        thresh [0:MAX_BANDS*MAX_MASK_H*MAX_MASK_W-1];
    logic [2:0]         band_count;
    logic signed [16:0] cube_offset;
    logic [4:0]         mask_w;
    logic [4:0]         mask_h;
    logic [32:0]        coeff [MAX_BANDS];
    color_t             pending_colors [$];
    int                 mismatches;

    function new();
      band_count = 3'd1;
      cube_offset = '0;
      mask_w = 5'd4;
      mask_h = 5'd4;
      foreach (coeff[i]) coeff[i] = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [32:0] val);
      case (idx)
        REG_BAND_COUNT:  band_count = val[2:0];
        REG_CUBE_OFFSET: cube_offset = val[16:0];
        REG_MASK_WIDTH:  mask_w = val[4:0];
        REG_MASK_HEIGHT: mask_h = val[4:0];
        REG_BAND0_COEFF: coeff[0] = val;
        REG_BAND1_COEFF: coeff[1] = val;
        REG_BAND2_COEFF: coeff[2] = val;
        REG_BAND3_COEFF: coeff[3] = val;
        default: ;
      endcase
    endfunction

    function int active_bands();
      return (int'(band_count) > MAX_BANDS) ? MAX_BANDS : int'(band_count);
    endfunction

    function int entry_addr(int k, logic [15:0] x, logic [15:0] y);
      int w;
      int h;
      w = (mask_w == 5'd0) ? 1 : (int'(mask_w) > MAX_MASK_W) ? MAX_MASK_W : int'(mask_w);
      h = (mask_h == 5'd0) ? 1 : (int'(mask_h) > MAX_MASK_H) ? MAX_MASK_H : int'(mask_h);
      return (k * MAX_MASK_H + (int'(y) % h)) * MAX_MASK_W + (int'(x) % w);
    endfunction

    function color_t predict_color(logic [127:0] d);
      longint      sum;
      longint      mult;
      longint      quot;
      logic [15:0] biased;
      logic [31:0] prod;
      int          k;
      int          a;
      color_t      c;
      sum = longint'(cube_offset);
      for (k = 0; k < active_bands(); k++) begin
        biased = d[16*k +: 16] ^ SAMPLE_BIAS;
        prod = 32'(biased) * 32'(coeff[k][15:0]);
        quot = longint'(prod[31:16]);
        mult = longint'($signed(coeff[k][32:16]));
        a = entry_addr(k, d[79:64], d[95:80]);
        sum += quot * mult;
        if (prod[15:0] > thresh[a[9:0]]) sum += mult;
      end
      c.index = sum[15:0];
      c.nonzero = (sum != 0);
      return c;
    endfunction

    function void note_word(logic op, logic [127:0] d);
      if (op == OP_LOAD) thresh[{d[97:96], d[105:102], d[101:98]}] = d[121:106];
      else pending_colors.push_back(predict_color(d));
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_word(logic [15:0] index, logic nonzero);
      color_t c;
      if (pending_colors.size() == 0) begin
        flag($sformatf("unexpected result index %h nonzero %b", index, nonzero));
        return;
      end
      c = pending_colors.pop_front();
      if (index !== c.index)
        flag($sformatf("color_index expected %h got %h", c.index, index));
      if (nonzero !== c.nonzero)
        flag($sformatf("index_nonzero expected %b got %b", c.nonzero, nonzero));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [3:0]   cfg_index = '0;
  logic [32:0]  cfg_data = '0;

  colorcube_scoreboard sb = new();
  bit   issued [0:MAX_BANDS*MAX_MASK_H*MAX_MASK_W-1];
  int   idle_pct = 0;
  int   stall_pct = 0;
  bit   hold_req = 1'b0;
  int   sent_words = 0;
  int   quiet_cycles = 0;

  ordered_dither_colorcube_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (out_tvalid === 1'b1 && out_tready) sb.check_word(out_tdata, out_tuser[0]);
    if (in_tvalid && in_tready === 1'b1) sb.note_word(in_tuser[0], in_tdata);
    if (cfg_valid && cfg_ready === 1'b1) sb.write_reg(cfg_index, cfg_data);
    if ((out_tvalid === 1'b1 && out_tready) || (in_tvalid && in_tready === 1'b1) ||
        (cfg_valid && cfg_ready === 1'b1)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [127:0] pack_word(logic [63:0] samples, logic [15:0] x,
                                             logic [15:0] y, logic [1:0] band,
                                             logic [3:0] col, logic [3:0] row,
                                             logic [15:0] value);
    return {6'd0, value, row, col, band, y, x, samples};
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [32:0] pick_coeff();
    logic [32:0] r;
    case ($urandom_range(6))
      0: r = '0;
      1: r = '1;
      2: r = {17'h0FFFF, 16'hFFFF};
      3: r = {17'h10000, 16'hFFFF};
      default: begin
        r[31:0] = $urandom;
        r[32] = $urandom_range(1);
      end
    endcase
    return r;
  endfunction

  task automatic send_word(logic op, logic [127:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= d;
    do @(posedge clk); while (in_tready !== 1'b1);
    sent_words++;
  endtask

  task automatic load_entry(logic [1:0] band, logic [3:0] col, logic [3:0] row,
                            logic [15:0] value);
    issued[{band, row, col}] = 1'b1;
    send_word(OP_LOAD, pack_word({$urandom, $urandom}, 16'($urandom), 16'($urandom),
                                 band, col, row, value));
  endtask

  // Every threshold that the pixel will read is loaded first.
  task automatic dither_pixel(logic [63:0] samples, logic [15:0] x, logic [15:0] y);
    int k;
    int a;
    for (k = 0; k < sb.active_bands(); k++) begin
      a = sb.entry_addr(k, x, y);
      if (!issued[a[9:0]]) load_entry(a[9:8], a[3:0], a[7:4], 16'($urandom));
    end
    send_word(OP_PIXEL, pack_word(samples, x, y, 2'($urandom_range(3)),
                                  4'($urandom_range(15)), 4'($urandom_range(15)),
                                  16'($urandom)));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (sb.pending_colors.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_registers(logic [2:0] nb, logic [16:0] off, logic [4:0] w,
                               logic [4:0] h, logic [32:0] c0, logic [32:0] c1,
                               logic [32:0] c2, logic [32:0] c3);
    logic [32:0] vals [8];
    int          i;
    drain();
    vals[REG_BAND_COUNT] = 33'(nb);
    vals[REG_CUBE_OFFSET] = 33'(off);
    vals[REG_MASK_WIDTH] = 33'(w);
    vals[REG_MASK_HEIGHT] = 33'(h);
    vals[REG_BAND0_COEFF] = c0;
    vals[REG_BAND1_COEFF] = c1;
    vals[REG_BAND2_COEFF] = c2;
    vals[REG_BAND3_COEFF] = c3;
    for (i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[3:0];
      cfg_data <= vals[i[2:0]];
      do @(posedge clk); while (cfg_ready !== 1'b1);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int count);
    int start;
    start = sent_words;
    while (sent_words - start < count) begin
      if ($urandom_range(99) < 10)
        load_entry(2'($urandom_range(3)), 4'($urandom_range(15)), 4'($urandom_range(15)),
                   16'($urandom));
      else
        dither_pixel({pick_sample(), pick_sample(), pick_sample(), pick_sample()},
                     16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int          p;
    logic [2:0]  nb;
    logic [4:0]  w;
    logic [4:0]  h;
    logic [16:0] off;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one band with a zero coefficient, so the index is zero.
    load_entry(2'd0, 4'd0, 4'd0, 16'h0000);
    dither_pixel({4{16'h8000}}, 16'd0, 16'd0);

    set_registers(3'd4, 17'd0, 5'd4, 5'd4, {17'h00001, 16'hFFFF}, {17'h1FFFF, 16'h0000},
                  {17'h10000, 16'h0001}, {17'h0FFFF, 16'h8000});
    load_entry(2'd1, 4'd0, 4'd0, 16'hFFFF);
    load_entry(2'd2, 4'd0, 4'd0, 16'h0001);
    load_entry(2'd3, 4'd0, 4'd0, 16'h0000);
    load_entry(2'd3, 4'd15, 4'd15, 16'hFFFF);
    dither_pixel({4{16'h8000}}, 16'd0, 16'd0);
    dither_pixel({4{16'h7FFF}}, 16'd4, 16'd8);
    // Band two fraction equal to its threshold, then one above it.
    dither_pixel({16'h0000, 16'h8001, 16'hFFFF, 16'h0001}, 16'd0, 16'd0);
    dither_pixel({16'h5555, 16'h8002, 16'h0000, 16'hAAAA}, 16'd0, 16'd0);
    dither_pixel({4{16'h7FFF}}, 16'hFFFF, 16'hFFFF);

    // No bands and the lowest offset: index wraps to zero while the sum is not zero.
    set_registers(3'd0, 17'h10000, 5'd0, 5'd31, '0, '0, '0, '0);
    dither_pixel({4{16'h1234}}, 16'hFFFF, 16'hFFFF);

    set_registers(3'd7, 17'h0FFFF, 5'd17, 5'd0, {17'h00001, 16'hFFFF}, {17'h1FFFF, 16'h0000},
                  {17'h10000, 16'h0001}, {17'h0FFFF, 16'h8000});
    dither_pixel({4{16'h7FFF}}, 16'hFFFF, 16'd0);

    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin nb = 3'd4; w = 5'd4;  h = 5'd4;  end
        1: begin nb = 3'd1; w = 5'd1;  h = 5'd16; end
        2: begin nb = 3'd2; w = 5'd16; h = 5'd1;  end
        3: begin nb = 3'd3; w = 5'd16; h = 5'd16; end
        4: begin nb = 3'd4; w = 5'($urandom); h = 5'($urandom); end
        5: begin nb = 3'd5; w = 5'd8;  h = 5'd8;  end
        6: begin nb = 3'd0; w = 5'($urandom); h = 5'($urandom); end
        default: begin nb = 3'd4; w = 5'd16; h = 5'd16; end
      endcase
      off = (p == 2) ? 17'h0FFFF : (p == 5) ? 17'h10000 : 17'($urandom);
      set_registers(nb, off, w, h, pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff());
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      run_random(PHASE_WORDS / 2);
      if (p == 4) begin
        hold_req = 1'b1;
      end else if (p == 1) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait (sb.pending_colors.size() == 0);
        @(posedge clk);
      end
      run_random(PHASE_WORDS / 2);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (sb.pending_colors.size() == 0);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
